// ----- rtl/core/fmfc_pkg.sv -----
// ----------------------------------------------------------------------------
// fmfc_pkg: shared constants for the first-match flow classifier
// Table size, field widths, command, action and register codes.
// ----------------------------------------------------------------------------
package fmfc_pkg;

  localparam int MaxRules = 16;
  localparam int IdxW     = $clog2(MaxRules);

  // Priority encode is split into groups of lanes
  localparam int GrpSize  = 4;
  localparam int NumGrp   = MaxRules / GrpSize;
  localparam int LocW     = $clog2(GrpSize);
  localparam int GrpW     = $clog2(NumGrp);

  localparam int CountW   = 5;
  localparam int ActW     = 2;
  localparam int FlagW    = 3;

  localparam logic CmdClassify = 1'b0;
  localparam logic CmdWrite    = 1'b1;

  localparam logic [ActW-1:0] ActPass     = 2'd0;
  localparam logic [ActW-1:0] ActRedirect = 2'd1;
  localparam logic [ActW-1:0] ActDrop     = 2'd2;

  // check_flags bits
  localparam int FlagSport = 0;
  localparam int FlagDport = 1;
  localparam int FlagProto = 2;

  // Configuration port
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 5;
  localparam logic [CfgIdxW-1:0] CfgRulesInUse    = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgDefaultAction = 1'd1;

endpackage

// ----- rtl/core/fmfc_if.sv -----
// ----------------------------------------------------------------------------
// fmfc_if: item channels of the flow classifier
// Valid/ready channels for flow/rule items and for classification results.
// ----------------------------------------------------------------------------
interface fmfc_in_if;
  import fmfc_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [3:0]        rule_index;
  logic [31:0]       src_ip;
  logic [31:0]       dst_ip;
  logic [15:0]       sport;
  logic [15:0]       dport;
  logic [7:0]        proto;
  logic [31:0]       src_mask;
  logic [31:0]       dst_mask;
  logic [FlagW-1:0]  check_flags;
  logic              rule_enable;
  logic [ActW-1:0]   rule_action;

  modport source (
    output valid, command, rule_index, src_ip, dst_ip, sport, dport,
           proto, src_mask, dst_mask, check_flags, rule_enable, rule_action,
    input  ready
  );
  modport sink (
    input  valid, command, rule_index, src_ip, dst_ip, sport, dport,
           proto, src_mask, dst_mask, check_flags, rule_enable, rule_action,
    output ready
  );
endinterface

interface fmfc_out_if;
  logic       valid;
  logic       ready;
  logic       accept;
  logic       matched;
  logic [3:0] matched_rule;

  modport source (output valid, accept, matched, matched_rule, input ready);
  modport sink   (input valid, accept, matched, matched_rule, output ready);
endinterface

// ----- rtl/core/first_match_flow_classifier_core.sv -----
// ----------------------------------------------------------------------------
// first_match_flow_classifier_core: ordered first-match 5-tuple classifier
// 16-entry rule table compared in parallel, first hit picked over two stages.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  -------   ---  -------------  ------------------------------------------
//  flow      in   valid/ready    command, rule fields / flow 5-tuple
//  verdict   out  valid/ready    accept, matched, matched_rule
//  cfg       in   cfg_we         cfg_index, cfg_data (no read-back)
//
//  One item per cycle while verdict is not stalled; a classify result passes
//  s1 capture at the accept edge, then s2 lane compare, s3 group encode and
//  s4 output, which drives verdict.
//  Rule writes land in the table at the accept edge and give no result.
//  Reset clears valid bits, rule enables and config registers; no clearing pass.
//  A stalled verdict holds s4, items behind fill gaps; flow.ready drops only when s1 holds.
//
module first_match_flow_classifier_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fmfc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [fmfc_pkg::CfgDataW-1:0] cfg_data,
  fmfc_in_if.sink                       flow,
  fmfc_out_if.source                    verdict
);
  import fmfc_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CountW-1:0] rules_in_use;
  logic [ActW-1:0]   dflt_action;

  always_ff @(posedge clk) begin
    if (rst) begin
      rules_in_use <= '0;
      dflt_action  <= ActPass;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgRulesInUse:    rules_in_use <= cfg_data[CountW-1:0];
        CfgDefaultAction: dflt_action  <= cfg_data[ActW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage enables: a stage loads when empty or when it drains downstream
  // --------------------------------------------------------------------------
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic s1_en, s2_en, s3_en, s4_en;

  assign s4_en      = !s4_valid || verdict.ready;
  assign s3_en      = !s3_valid || s4_en;
  assign s2_en      = !s2_valid || s3_en;
  assign s1_en      = !s1_valid || s2_en;
  assign flow.ready = s1_en;

  logic flow_take;
  assign flow_take = flow.valid && flow.ready;

  // --------------------------------------------------------------------------
  // Rule table: flops, each lane read at its own fixed place
  // --------------------------------------------------------------------------
  logic [31:0]      rule_src_prefix  [MaxRules];
  logic [31:0]      rule_src_mask    [MaxRules];
  logic [31:0]      rule_dst_prefix  [MaxRules];
  logic [31:0]      rule_dst_mask    [MaxRules];
  logic [15:0]      rule_sport       [MaxRules];
  logic [15:0]      rule_dport       [MaxRules];
  logic [7:0]       rule_proto       [MaxRules];
  logic [FlagW-1:0] rule_check_flags [MaxRules];
  logic [ActW-1:0]  rule_action_codes[MaxRules];
  logic [MaxRules-1:0] rule_enabled_bits;

  // Write at the accept edge: older classify items already in s1 compare
  // against the old table on the same edge, so item order is kept.
  always_ff @(posedge clk) begin
    if (flow_take && flow.command == CmdWrite) begin
      rule_src_prefix[flow.rule_index]   <= flow.src_ip;
      rule_src_mask[flow.rule_index]     <= flow.src_mask;
      rule_dst_prefix[flow.rule_index]   <= flow.dst_ip;
      rule_dst_mask[flow.rule_index]     <= flow.dst_mask;
      rule_sport[flow.rule_index]        <= flow.sport;
      rule_dport[flow.rule_index]        <= flow.dport;
      rule_proto[flow.rule_index]        <= flow.proto;
      rule_check_flags[flow.rule_index]  <= flow.check_flags;
      rule_action_codes[flow.rule_index] <= flow.rule_action;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_enabled_bits <= '0;
    end else if (flow_take && flow.command == CmdWrite) begin
      rule_enabled_bits[flow.rule_index] <= flow.rule_enable;
    end
  end

  // --------------------------------------------------------------------------
  // s1: capture classify items (writes are done on accept and leave here)
  // --------------------------------------------------------------------------
  logic [31:0] s1_src_ip, s1_dst_ip;
  logic [15:0] s1_sport, s1_dport;
  logic [7:0]  s1_proto;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= flow_take && flow.command == CmdClassify;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_src_ip <= flow.src_ip;
      s1_dst_ip <= flow.dst_ip;
      s1_sport  <= flow.sport;
      s1_dport  <= flow.dport;
      s1_proto  <= flow.proto;
    end
  end

  // --------------------------------------------------------------------------
  // s2: per-lane hit and redirect bits. A lane is live when its index is
  // below rules_in_use; values above the table size cover every lane.
  // --------------------------------------------------------------------------
  logic [MaxRules-1:0] hit_next, redir_next;
  logic [MaxRules-1:0] s2_hit, s2_redir;
  logic                s2_empty;

  always_comb begin
    for (int i = 0; i < MaxRules; i++) begin
      hit_next[i] = (CountW'(i) < rules_in_use) && rule_enabled_bits[i]
        && ((s1_src_ip & rule_src_mask[i]) == (rule_src_prefix[i] & rule_src_mask[i]))
        && ((s1_dst_ip & rule_dst_mask[i]) == (rule_dst_prefix[i] & rule_dst_mask[i]))
        && (!rule_check_flags[i][FlagSport] || s1_sport == rule_sport[i])
        && (!rule_check_flags[i][FlagDport] || s1_dport == rule_dport[i])
        && (!rule_check_flags[i][FlagProto] || s1_proto == rule_proto[i]);
      // action captured now, a later write must not change this item's verdict
      redir_next[i] = rule_action_codes[i] == ActRedirect;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_hit   <= hit_next;
      s2_redir <= redir_next;
      s2_empty <= rules_in_use == '0;
    end
  end

  // --------------------------------------------------------------------------
  // s3: first hit inside each group of lanes
  // --------------------------------------------------------------------------
  logic [NumGrp-1:0] grp_any_next, grp_redir_next;
  logic [LocW-1:0]   grp_loc_next [NumGrp];
  logic [NumGrp-1:0] s3_grp_any, s3_grp_redir;
  logic [LocW-1:0]   s3_grp_loc [NumGrp];
  logic              s3_empty;

  always_comb begin
    for (int g = 0; g < NumGrp; g++) begin
      grp_any_next[g]   = 1'b0;
      grp_redir_next[g] = 1'b0;
      grp_loc_next[g]   = '0;
      // walk down so the lowest hit wins
      for (int k = GrpSize - 1; k >= 0; k--) begin
        if (s2_hit[g*GrpSize + k]) begin
          grp_any_next[g]   = 1'b1;
          grp_redir_next[g] = s2_redir[g*GrpSize + k];
          grp_loc_next[g]   = LocW'(k);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_grp_any   <= grp_any_next;
      s3_grp_redir <= grp_redir_next;
      s3_grp_loc   <= grp_loc_next;
      s3_empty     <= s2_empty;
    end
  end

  // --------------------------------------------------------------------------
  // s4: first group, verdict. Empty table accepts; no hit takes default.
  // --------------------------------------------------------------------------
  logic            matched_next, accept_next, sel_redir;
  logic [IdxW-1:0] rule_next;
  logic            s4_accept, s4_matched;
  logic [IdxW-1:0] s4_rule;

  always_comb begin
    matched_next = 1'b0;
    sel_redir    = 1'b0;
    rule_next    = '0;
    for (int g = NumGrp - 1; g >= 0; g--) begin
      if (s3_grp_any[g]) begin
        matched_next = 1'b1;
        sel_redir    = s3_grp_redir[g];
        rule_next    = {GrpW'(g), s3_grp_loc[g]};
      end
    end
    if (s3_empty) begin
      accept_next = 1'b1;
    end else if (matched_next) begin
      accept_next = sel_redir;
    end else begin
      accept_next = dflt_action == ActRedirect;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_en) begin
      s4_accept  <= accept_next;
      s4_matched <= matched_next;
      s4_rule    <= rule_next;
    end
  end

  assign verdict.valid        = s4_valid;
  assign verdict.accept       = s4_accept;
  assign verdict.matched      = s4_matched;
  assign verdict.matched_rule = s4_rule;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  // a rule write never becomes a pipeline item
  a_write_no_item: assert property (@(posedge clk) disable iff (rst)
    flow_take && flow.command == CmdWrite |=> !s1_valid)
    else $error("rule write entered the pipeline");

  // a held verdict keeps its payload
  a_verdict_hold: assert property (@(posedge clk) disable iff (rst)
    s4_valid && !verdict.ready |=> s4_valid && $stable(s4_rule)
      && $stable(s4_accept) && $stable(s4_matched))
    else $error("stalled verdict changed");

  // an item stuck in s1 stays there
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_en |=> s1_valid && $stable(s1_src_ip))
    else $error("s1 item lost under stall");

  // an empty table never reports a match
  a_empty_no_match: assert property (@(posedge clk) disable iff (rst)
    s3_valid && s3_empty |-> s3_grp_any == '0)
    else $error("hit with no rules in use");

endmodule

// ----- test/tb_first_match_flow_classifier_core.sv -----
// ----------------------------------------------------------------------------
// tb_first_match_flow_classifier_core: self-checking bench for the classifier
// Drives rule writes and flow lookups over the item channel, keeps its own
// copy of the rule table and registers, and checks every verdict in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_first_match_flow_classifier_core;
  import fmfc_pkg::*;

  localparam int LatencyPause = 8;     // quiet cycles before a register write
  localparam int DrainTail    = 12;    // cycles watched after the last verdict
  localparam int HoldCycles   = 300;   // long verdict hold-off
  localparam int StallLimit   = 4000;  // cycles with no handshake at all

  // action code with no meaning; never accepts
  localparam logic [ActW-1:0] ActUnknown = 2'd3;

  typedef struct packed {
    logic [31:0]      src_pfx;
    logic [31:0]      src_msk;
    logic [31:0]      dst_pfx;
    logic [31:0]      dst_msk;
    logic [15:0]      sport;
    logic [15:0]      dport;
    logic [7:0]       proto;
    logic [FlagW-1:0] flags;
    logic             en;
    logic [ActW-1:0]  act;
  } acl_rule_t;

  typedef struct packed {
    logic             command;
    logic [3:0]       rule_index;
    logic [31:0]      src_ip;
    logic [31:0]      dst_ip;
    logic [15:0]      sport;
    logic [15:0]      dport;
    logic [7:0]       proto;
    logic [31:0]      src_mask;
    logic [31:0]      dst_mask;
    logic [FlagW-1:0] check_flags;
    logic             rule_enable;
    logic [ActW-1:0]  rule_action;
  } flow_item_t;

  typedef struct packed {
    logic       accept;
    logic       matched;
    logic [3:0] matched_rule;
  } verdict_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  fmfc_in_if  flow_bus ();
  fmfc_out_if verdict_bus ();

  first_match_flow_classifier_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .flow      (flow_bus),
    .verdict   (verdict_bus)
  );

  // Bench copy of the block state
  acl_rule_t           acl_table [MaxRules];
  logic [CountW-1:0]   cur_rules_in_use = '0;
  logic [ActW-1:0]     cur_dflt_action  = ActPass;
  verdict_t            pending_verdicts [$];

  int error_count  = 0;
  int verdict_hold = 0;   // set by a test, counted down by the ready process
  bit gaps_on      = 1'b1;
  bit stall_on     = 1'b1;
  bit offering     = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Idle stretch: mostly a few cycles, now and then a long one
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // First enabled hit among the consulted entries decides the verdict.
  function automatic verdict_t classify_flow(input flow_item_t f);
    verdict_t  v;
    acl_rule_t r;
    int        n;
    int        i;
    bit        hit;
    // rules_in_use above the table size saturates
    n = (cur_rules_in_use > MaxRules) ? MaxRules : int'(cur_rules_in_use);
    // empty table accepts everything; otherwise the default decides a miss
    v.accept       = (n == 0) || (cur_dflt_action == ActRedirect);
    v.matched      = 1'b0;
    v.matched_rule = '0;
    for (i = 0; i < n && !v.matched; i++) begin
      r   = acl_table[i];
      hit = r.en
        && ((f.src_ip & r.src_msk) == (r.src_pfx & r.src_msk))
        && ((f.dst_ip & r.dst_msk) == (r.dst_pfx & r.dst_msk))
        && (!r.flags[FlagSport] || f.sport == r.sport)
        && (!r.flags[FlagDport] || f.dport == r.dport)
        && (!r.flags[FlagProto] || f.proto == r.proto);
      if (hit) begin
        // action code 3 is unknown and never accepts
        v.accept       = (r.act == ActRedirect);
        v.matched      = 1'b1;
        v.matched_rule = 4'(i);
      end
    end
    return v;
  endfunction

  function automatic logic [31:0] rand_mask();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return '0;
    if (r < 40) return '1;
    if (r < 85) return ~(32'hFFFF_FFFF >> $urandom_range(1, 31));
    return $urandom();
  endfunction

  function automatic acl_rule_t random_rule();
    acl_rule_t r;
    r.src_pfx = $urandom();
    r.src_msk = rand_mask();
    r.dst_pfx = $urandom();
    r.dst_msk = rand_mask();
    r.sport   = 16'($urandom());
    r.dport   = 16'($urandom());
    r.proto   = 8'($urandom());
    r.flags   = FlagW'($urandom_range(0, 7));
    r.en      = ($urandom_range(0, 3) != 0);
    r.act     = ActW'($urandom_range(0, 3));
    return r;
  endfunction

  // Classify item with every field random, write-only fields included
  function automatic flow_item_t random_flow();
    flow_item_t it;
    it.command     = CmdClassify;
    it.rule_index  = 4'($urandom());
    it.src_ip      = $urandom();
    it.dst_ip      = $urandom();
    it.sport       = 16'($urandom());
    it.dport       = 16'($urandom());
    it.proto       = 8'($urandom());
    it.src_mask    = $urandom();
    it.dst_mask    = $urandom();
    it.check_flags = FlagW'($urandom());
    it.rule_enable = 1'($urandom());
    it.rule_action = ActW'($urandom());
    return it;
  endfunction

  function automatic flow_item_t make_flow(input logic [31:0] sip, input logic [31:0] dip,
                                           input logic [15:0] sp, input logic [15:0] dp,
                                           input logic [7:0] pr);
    flow_item_t it;
    it        = random_flow();
    it.src_ip = sip;
    it.dst_ip = dip;
    it.sport  = sp;
    it.dport  = dp;
    it.proto  = pr;
    return it;
  endfunction

  function automatic flow_item_t rule_to_item(input logic [3:0] idx, input acl_rule_t r);
    flow_item_t it;
    it             = random_flow();
    it.command     = CmdWrite;
    it.rule_index  = idx;
    it.src_ip      = r.src_pfx;
    it.src_mask    = r.src_msk;
    it.dst_ip      = r.dst_pfx;
    it.dst_mask    = r.dst_msk;
    it.sport       = r.sport;
    it.dport       = r.dport;
    it.proto       = r.proto;
    it.check_flags = r.flags;
    it.rule_enable = r.en;
    it.rule_action = r.act;
    return it;
  endfunction

  // Random traffic: some rule writes, mostly flows aimed at a consulted
  // rule, some near misses of one, and the rest pure noise.
  function automatic flow_item_t next_random_item();
    flow_item_t  it;
    acl_rule_t   r;
    logic [31:0] m;
    int          kind;
    int          n;
    it   = random_flow();
    kind = $urandom_range(0, 99);
    n    = (cur_rules_in_use > MaxRules) ? MaxRules : int'(cur_rules_in_use);
    if (kind < 15) begin
      it = rule_to_item(4'($urandom_range(0, MaxRules - 1)), random_rule());
    end else if (kind < 75 && n > 0) begin
      r         = acl_table[$urandom_range(0, n - 1)];
      it.src_ip = (r.src_pfx & r.src_msk) | (it.src_ip & ~r.src_msk);
      it.dst_ip = (r.dst_pfx & r.dst_msk) | (it.dst_ip & ~r.dst_msk);
      if (r.flags[FlagSport]) it.sport = r.sport;
      if (r.flags[FlagDport]) it.dport = r.dport;
      if (r.flags[FlagProto]) it.proto = r.proto;
      if (kind >= 60) begin
        // near miss: try to break one field (source, destination or protocol)
        case ($urandom_range(0, 2))
          0: begin
            m = r.src_msk & $urandom();
            if (m == 0) m = r.src_msk & (~r.src_msk + 32'd1);
            it.src_ip ^= m;
          end
          1: begin
            m = r.dst_msk & $urandom();
            if (m == 0) m = r.dst_msk & (~r.dst_msk + 32'd1);
            it.dst_ip ^= m;
          end
          default: begin
            it.proto ^= 8'($urandom_range(1, 255));
          end
        endcase
      end
    end
    return it;
  endfunction

  task automatic rest_flow();
    if (offering) begin
      flow_bus.valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // Offer one item, wait for the handshake, then update the bench copy.
  // valid stays high on return so a back-to-back item needs no gap.
  task automatic send_flow(input flow_item_t it);
    int gap;
    gap = (gaps_on && $urandom_range(0, 99) < 35) ? idle_len() : 0;
    if (gap > 0) begin
      rest_flow();
      repeat (gap) @(posedge clk);
    end
    flow_bus.valid       <= 1'b1;
    flow_bus.command     <= it.command;
    flow_bus.rule_index  <= it.rule_index;
    flow_bus.src_ip      <= it.src_ip;
    flow_bus.dst_ip      <= it.dst_ip;
    flow_bus.sport       <= it.sport;
    flow_bus.dport       <= it.dport;
    flow_bus.proto       <= it.proto;
    flow_bus.src_mask    <= it.src_mask;
    flow_bus.dst_mask    <= it.dst_mask;
    flow_bus.check_flags <= it.check_flags;
    flow_bus.rule_enable <= it.rule_enable;
    flow_bus.rule_action <= it.rule_action;
    offering = 1'b1;
    do @(posedge clk); while (!flow_bus.ready);
    if (it.command == CmdWrite) begin
      acl_table[it.rule_index] = '{it.src_ip, it.src_mask, it.dst_ip, it.dst_mask,
                                   it.sport, it.dport, it.proto,
                                   it.check_flags, it.rule_enable, it.rule_action};
    end else begin
      pending_verdicts.push_back(classify_flow(it));
    end
  endtask

  task automatic wait_drained();
    rest_flow();
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // Both registers are written back to back, only with the block idle.
  // A write item lands in the table at its accept edge, so none is in flight after the last verdict.
  task automatic set_config(input logic [CountW-1:0] rules, input logic [ActW-1:0] dflt);
    wait_drained();
    repeat (LatencyPause) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CfgRulesInUse;
    cfg_data  <= CfgDataW'(rules);
    @(posedge clk);
    cfg_index <= CfgDefaultAction;
    cfg_data  <= CfgDataW'(dflt);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_rules_in_use = rules;
    cur_dflt_action  = dflt;
  endtask

  // Result side ready: long hold-off first, then random stalls.
  initial begin : verdict_ready_gen
    int stall_left;
    stall_left = 0;
    verdict_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (verdict_hold > 0) begin
        verdict_bus.ready <= 1'b0;
        verdict_hold--;
      end else if (stall_left > 0) begin
        verdict_bus.ready <= 1'b0;
        stall_left--;
      end else if (stall_on && $urandom_range(0, 99) < 25) begin
        verdict_bus.ready <= 1'b0;
        stall_left = idle_len() - 1;
      end else begin
        verdict_bus.ready <= 1'b1;
      end
    end
  end

  // Every verdict taken is compared with the oldest prediction.
  always @(posedge clk) begin : verdict_checker
    verdict_t want;
    if (!rst && verdict_bus.valid && verdict_bus.ready) begin
      if (pending_verdicts.size() == 0) begin
        flag_error($sformatf("verdict with none pending: accept=%0b matched=%0b rule=%0d",
                             verdict_bus.accept, verdict_bus.matched,
                             verdict_bus.matched_rule));
      end else begin
        want = pending_verdicts.pop_front();
        if (verdict_bus.accept !== want.accept)
          flag_error($sformatf("accept got %0b want %0b", verdict_bus.accept, want.accept));
        if (verdict_bus.matched !== want.matched)
          flag_error($sformatf("matched got %0b want %0b", verdict_bus.matched,
                               want.matched));
        if (verdict_bus.matched_rule !== want.matched_rule)
          flag_error($sformatf("matched_rule got %0d want %0d", verdict_bus.matched_rule,
                               want.matched_rule));
      end
    end
  end

  // Ends a run in which the channels stop moving.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if (rst || (flow_bus.valid && flow_bus.ready) ||
          (verdict_bus.valid && verdict_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

  // Reset state: no rules consulted, every flow accepted.
  task automatic test_empty_table();
    send_flow(make_flow('0, '0, '0, '0, '0));
    send_flow(make_flow('1, '1, '1, '1, '1));
    set_config(5'd0, ActDrop);
    send_flow(random_flow());
  endtask

  // Hand-built table: prefix, exact match, port and proto checks,
  // a disabled catch-all, a catch-all with unknown action, and the default.
  task automatic test_first_match();
    send_flow(rule_to_item(4'd0, '{src_pfx: 32'h0A00_0000, src_msk: 32'hFF00_0000,
                                   dst_pfx: 32'h1234_5678, dst_msk: '0,
                                   sport: 16'd80, dport: 16'd0, proto: 8'd0,
                                   flags: 3'b001, en: 1'b1, act: ActRedirect}));
    send_flow(rule_to_item(4'd1, '{src_pfx: 32'hC0A8_0101, src_msk: '1,
                                   dst_pfx: 32'hAC10_0000, dst_msk: 32'hFFFF_0000,
                                   sport: 16'hFFFF, dport: 16'd443, proto: 8'd6,
                                   flags: 3'b110, en: 1'b1, act: ActDrop}));
    send_flow(rule_to_item(4'd2, '{src_pfx: '1, src_msk: '0, dst_pfx: '1, dst_msk: '0,
                                   sport: '1, dport: '1, proto: '1,
                                   flags: 3'b000, en: 1'b0, act: ActRedirect}));
    send_flow(rule_to_item(4'd3, '{src_pfx: '0, src_msk: '0, dst_pfx: '0, dst_msk: '0,
                                   sport: '0, dport: '0, proto: '0,
                                   flags: 3'b000, en: 1'b1, act: ActUnknown}));
    set_config(5'd4, ActRedirect);
    send_flow(make_flow(32'h0A12_3456, $urandom(), 16'd80, 16'($urandom()), 8'd17));
    send_flow(make_flow(32'h0A12_3456, $urandom(), 16'd81, 16'($urandom()), 8'd17));
    send_flow(make_flow(32'hC0A8_0101, 32'hAC10_FFFF, 16'd1234, 16'd443, 8'd6));
    send_flow(make_flow(32'hC0A8_0101, 32'hAC10_FFFF, 16'd1234, 16'd443, 8'd17));
    send_flow(make_flow('1, '1, '1, '1, '1));
    // catch-all out of range: misses fall to the default
    set_config(5'd3, ActRedirect);
    send_flow(make_flow('1, '1, '1, '1, '1));
    send_flow(make_flow('0, '0, '0, '0, '0));
    set_config(5'd3, ActUnknown);
    send_flow(make_flow('0, '0, '0, '0, '0));
  endtask

  // Fill the whole table, then run segments under different settings,
  // including counts past the table size.
  task automatic test_random_traffic();
    int seg_rules [8];
    int seg;
    int k;
    seg_rules = '{16, 31, 1, 17, 0, 8, 16, 5};
    for (k = 0; k < MaxRules; k++) send_flow(rule_to_item(4'(k), random_rule()));
    for (seg = 0; seg < 8; seg++) begin
      if (seg == 7) seg_rules[seg] = $urandom_range(0, 31);
      set_config(CountW'(seg_rules[seg]), ActW'($urandom_range(0, 3)));
      gaps_on  = (seg != 2);
      stall_on = (seg != 2);
      for (k = 0; k < 150; k++) begin
        if ($urandom_range(0, 99) == 0) wait_drained();
        send_flow(next_random_item());
      end
    end
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  // Verdicts held off while the sender keeps offering, so the pipe fills
  // and the item channel stalls; then the sender waits for a full drain.
  task automatic test_backpressure();
    int k;
    set_config(5'd16, ActRedirect);
    gaps_on      = 1'b0;
    verdict_hold = HoldCycles;
    for (k = 0; k < 40; k++) send_flow(next_random_item());
    wait_drained();
    gaps_on = 1'b1;
    for (k = 0; k < 20; k++) send_flow(next_random_item());
  endtask

  initial begin
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= CfgRulesInUse;
    cfg_data             <= '0;
    flow_bus.valid       <= 1'b0;
    flow_bus.command     <= CmdClassify;
    flow_bus.rule_index  <= '0;
    flow_bus.src_ip      <= '0;
    flow_bus.dst_ip      <= '0;
    flow_bus.sport       <= '0;
    flow_bus.dport       <= '0;
    flow_bus.proto       <= '0;
    flow_bus.src_mask    <= '0;
    flow_bus.dst_mask    <= '0;
    flow_bus.check_flags <= '0;
    flow_bus.rule_enable <= 1'b0;
    flow_bus.rule_action <= ActPass;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_first_match();
    test_random_traffic();
    test_backpressure();

    wait_drained();
    repeat (DrainTail) @(posedge clk);
    if (error_count == 0 && pending_verdicts.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
